// ===== hw/rtl/sha_pkg.sv =====
// shared types and constants for the sha-256 stream hasher
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] chain_t;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned BLOCK_BYTES = 64;

  localparam logic [5:0] FILL_LEN_AT = 6'd56;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       restart;
  } core_ctrl_t;

  typedef struct packed {
    logic       ready;
    logic [5:0] fill;
  } core_stat_t;

endpackage

// ===== hw/rtl/sha_stream_if.sv =====
// stream interfaces for message bytes and digest words
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte, output end_of_message,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input end_of_message,
                output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ===== hw/rtl/sha_core.sv =====
// block buffer, message schedule window and one-round-per-cycle compression
module sha_core (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::core_ctrl_t ctrl,
  output sha_pkg::core_stat_t stat,
  output sha_pkg::chain_t     chain_out
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} core_state_t;

  core_state_t   state;
  logic [5:0]    rnd;
  logic [5:0]    fill;
  logic [511:0]  blk;
  sha_pkg::word_t v [8];
  sha_pkg::word_t chain [8];

  sha_pkg::word_t w_t, w_1, w_9, w_14, w_new, t1, t2;

  function automatic sha_pkg::word_t bsig0(input sha_pkg::word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic sha_pkg::word_t bsig1(input sha_pkg::word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic sha_pkg::word_t ssig0(input sha_pkg::word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic sha_pkg::word_t ssig1(input sha_pkg::word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  // window word j sits at blk[511-32j -: 32]
  assign w_t  = blk[511:480];
  assign w_1  = blk[479:448];
  assign w_9  = blk[223:192];
  assign w_14 = blk[63:32];

  always_comb begin
    w_new = w_t + ssig0(w_1) + w_9 + ssig1(w_14);
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[rnd] + w_t;
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_comb begin
    stat.ready = (state == C_IDLE);
    stat.fill = fill;
    for (int i = 0; i < 8; i++) begin
      chain_out[i] = chain[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      rnd <= '0;
      fill <= '0;
      chain <= sha_pkg::INIT_H;
    end else begin
      case (state)
        C_IDLE: begin
          if (ctrl.restart) begin
            chain <= sha_pkg::INIT_H;
            fill <= '0;
          end else if (ctrl.push) begin
            blk <= {blk[503:0], ctrl.push_byte};
            fill <= fill + 6'd1;
            if (fill == 6'(sha_pkg::BLOCK_BYTES - 1)) begin
              v <= chain;
              rnd <= '0;
              state <= C_ROUND;
            end
          end
        end
        C_ROUND: begin
          blk <= {blk[479:0], w_new};
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'(sha_pkg::ROUNDS - 1)) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  a_push_when_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |-> state == C_IDLE)
    else $error("byte pushed while compression runs");

  a_full_starts: assert property (@(posedge clk) disable iff (rst)
    (state == C_IDLE && ctrl.push && !ctrl.restart && fill == 6'(sha_pkg::BLOCK_BYTES - 1))
      |=> (state == C_ROUND && rnd == '0 && fill == '0))
    else $error("full block did not start compression");

  a_restart_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.restart |-> (state == C_IDLE && !ctrl.push))
    else $error("restart outside idle or with a push");

endmodule

// ===== hw/rtl/sha256_stream_hasher.sv =====
// sha-256 over a byte stream with padding and digest word output
// a byte transaction with has_byte set pushes one byte; every 64th byte, padding included, starts a compression
// (64 rounds of the shared round unit, one per cycle, plus one chaining add)
// end of message: the mark byte, zero bytes until the fill reaches 56, 8 length bytes,
// one or two compressions, then 8 digest words at one per cycle when taken
// rst is synchronous: initial hash loaded, length and fill cleared, no words pending
module sha256_stream_hasher (
  input  logic      clk,
  input  logic      rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_MARK, S_ZERO, S_LEN, S_DRAIN, S_EMIT} top_state_t;

  top_state_t          st;
  logic [2:0]          len_cnt;
  logic [2:0]          idx;
  logic [63:0]         message_bits;
  sha_pkg::core_ctrl_t core_ctrl;
  sha_pkg::core_stat_t core_stat;
  sha_pkg::chain_t     chain;
  logic                in_fire, out_fire;

  sha_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (core_ctrl),
    .stat     (core_stat),
    .chain_out(chain)
  );

  assign in_ch.ready = (st == S_IDLE) && core_stat.ready;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign out_ch.valid = (st == S_EMIT);
  assign out_ch.digest_word = chain[idx];
  assign out_ch.word_index = idx;
  assign out_ch.last_word = (idx == sha_pkg::LAST_WORD_IDX);
  assign out_fire = out_ch.valid && out_ch.ready;

  always_comb begin
    core_ctrl.push = 1'b0;
    core_ctrl.push_byte = '0;
    core_ctrl.restart = 1'b0;
    case (st)
      S_IDLE: begin
        core_ctrl.push = in_fire && in_ch.has_byte;
        core_ctrl.push_byte = in_ch.data_byte;
      end
      S_MARK: begin
        core_ctrl.push = core_stat.ready;
        core_ctrl.push_byte = sha_pkg::PAD_MARK;
      end
      S_ZERO: begin
        core_ctrl.push = core_stat.ready && (core_stat.fill != sha_pkg::FILL_LEN_AT);
      end
      S_LEN: begin
        core_ctrl.push = core_stat.ready;
        core_ctrl.push_byte = message_bits[63:56];
      end
      S_EMIT: begin
        core_ctrl.restart = out_fire && out_ch.last_word;
      end
      default: begin
        core_ctrl.push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      len_cnt <= '0;
      idx <= '0;
      message_bits <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.has_byte) begin
              message_bits <= message_bits + 64'd8;
            end
            if (in_ch.end_of_message) begin
              st <= S_MARK;
            end
          end
        end
        S_MARK: begin
          if (core_stat.ready) begin
            st <= S_ZERO;
          end
        end
        S_ZERO: begin
          if (core_stat.ready && core_stat.fill == sha_pkg::FILL_LEN_AT) begin
            len_cnt <= '0;
            st <= S_LEN;
          end
        end
        S_LEN: begin
          if (core_stat.ready) begin
            message_bits <= {message_bits[55:0], message_bits[63:56]};
            len_cnt <= len_cnt + 3'd1;
            if (len_cnt == 3'd7) begin
              st <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (core_stat.ready) begin
            idx <= '0;
            st <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_fire) begin
            idx <= idx + 3'd1;
            if (out_ch.last_word) begin
              message_bits <= '0;
              st <= S_IDLE;
            end
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_core_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> core_stat.ready)
    else $error("transaction accepted while core busy");

  a_len_aligned: assert property (@(posedge clk) disable iff (rst)
    (st == S_DRAIN && core_stat.ready) |-> core_stat.fill == '0)
    else $error("padded message not block aligned");

  a_restart_clean: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_ch.last_word) |=> (st == S_IDLE && message_bits == '0
      && core_stat.fill == '0))
    else $error("state not reinitialized after digest");

endmodule
